[rtl/acrms_pkg.sv]
package acrms_pkg;

  // Sample and window sizes.
  localparam int unsigned ADC_BITS   = 12;
  localparam int unsigned ADC_MAX    = (1 << ADC_BITS) - 1;
  localparam int unsigned MAX_WINDOW = 65536;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned CH_W       = 2;
  localparam int unsigned CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W      = 29;
  localparam int unsigned SQ_W       = 41;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned UV_W       = 22;
  localparam int unsigned UA_W       = 28;

  // Scaling constants.
  localparam int unsigned FULL_SCALE_UV = 3300000;
  localparam int unsigned RMS_DEN       = ADC_MAX * 65536;
  localparam int unsigned UA_DIV        = 1000;

  // Serial arithmetic units.
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned DIV_W      = 73;
  localparam int unsigned DVS_W      = 28;
  localparam int unsigned RAD_W      = 56;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned SQREM_W    = ROOT_W + 2;
  localparam int unsigned STEP_W     = 7;

  // Register indexes of the configuration port.
  localparam logic [CH_W-1:0] REG_GAIN_ONE   = 2'd0;
  localparam logic [CH_W-1:0] REG_GAIN_TWO   = 2'd1;
  localparam logic [CH_W-1:0] REG_GAIN_THREE = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_ONE_RESET   = 16'd778;
  localparam logic [GAIN_W-1:0] GAIN_TWO_RESET   = 16'd377;
  localparam logic [GAIN_W-1:0] GAIN_THREE_RESET = 16'd863;

  localparam logic [UV_W-1:0] OFFSET_ONE_RESET   = 22'd4060;
  localparam logic [UV_W-1:0] OFFSET_TWO_RESET   = 22'd3960;
  localparam logic [UV_W-1:0] OFFSET_THREE_RESET = 22'd2740;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_STORE,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_SPLIT,
    OP_SUB,
    OP_VAR,
    OP_FRAC,
    OP_FSQ,
    OP_ROOT,
    OP_RMS_MUL,
    OP_RMS_DIV,
    OP_MEAN_MUL,
    OP_MEAN_DIV,
    OP_RAW_MUL,
    OP_RAW_DIV,
    OP_OFF_MUL,
    OP_OFF_DIV
  } op_t;

  typedef enum logic [1:0] {
    UNIT_MUL,
    UNIT_DIV,
    UNIT_SQRT
  } unit_t;

  function automatic unit_t op_unit(op_t op);
    unit_t u;
    case (op)
      OP_SUB, OP_FSQ, OP_RMS_MUL, OP_MEAN_MUL, OP_RAW_MUL, OP_OFF_MUL: u = UNIT_MUL;
      OP_ROOT: u = UNIT_SQRT;
      default: u = UNIT_DIV;
    endcase
    return u;
  endfunction

  function automatic logic [STEP_W-1:0] op_steps(op_t op);
    logic [STEP_W-1:0] n;
    case (op_unit(op))
      UNIT_MUL:  n = STEP_W'(MUL_W);
      UNIT_SQRT: n = STEP_W'(ROOT_W);
      default:   n = STEP_W'(DIV_W);
    endcase
    return n;
  endfunction

  function automatic op_t op_next(op_t op);
    op_t n;
    case (op)
      OP_SPLIT:    n = OP_SUB;
      OP_SUB:      n = OP_VAR;
      OP_VAR:      n = OP_FRAC;
      OP_FRAC:     n = OP_FSQ;
      OP_FSQ:      n = OP_ROOT;
      OP_ROOT:     n = OP_RMS_MUL;
      OP_RMS_MUL:  n = OP_RMS_DIV;
      OP_RMS_DIV:  n = OP_MEAN_MUL;
      OP_MEAN_MUL: n = OP_MEAN_DIV;
      OP_MEAN_DIV: n = OP_RAW_MUL;
      OP_RAW_MUL:  n = OP_RAW_DIV;
      OP_RAW_DIV:  n = OP_OFF_MUL;
      OP_OFF_MUL:  n = OP_OFF_DIV;
      default:     n = OP_SPLIT;
    endcase
    return n;
  endfunction

endpackage

[rtl/ac_rms_current_meter.sv]
// Three-channel true RMS current meter. A sample request is taken only while idle and is
// added to its channel's sum, sum of squares and count; chan 3 is ignored. A sample
// marked window_end also closes the window: the block then runs a fixed sequence on a
// shared bit-serial multiplier, a shared restoring divider (one quotient bit a cycle)
// and a digit-by-digit square root, and takes no new sample until the result has been
// loaded into the output register. The result waits in that register, so sampling
// resumes while it is still pending. Gains may be written only while idle.
module ac_rms_current_meter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_chan,
  input  logic [11:0]                 in_raw_sample,
  input  logic                        in_window_end,
  input  logic                        in_calibrate,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_result_chan,
  output logic [27:0]                 out_corrected_current_ua,
  output logic [27:0]                 out_raw_current_ua,
  output logic [27:0]                 out_offset_current_ua,
  output logic [21:0]                 out_rms_voltage_uv,
  output logic [21:0]                 out_mean_voltage_uv,
  output logic [16:0]                 out_samples_used,
  output logic                        out_window_clipped,
  output logic                        out_offset_updated,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_wdata
);

  localparam int unsigned NCH = acrms_pkg::NUM_CH;

  // Control.
  acrms_pkg::state_t state_r, state_nxt;
  acrms_pkg::op_t    op_r;
  logic [acrms_pkg::STEP_W-1:0] step_r;
  logic unit_load, unit_step, res_store, out_load, out_free;

  // Per-channel state.
  logic [acrms_pkg::GAIN_W-1:0] gain_r    [NCH];
  logic [acrms_pkg::SUM_W-1:0]  acc_sum_r [NCH];
  logic [acrms_pkg::SQ_W-1:0]   acc_sq_r  [NCH];
  logic [acrms_pkg::CNT_W-1:0]  acc_cnt_r [NCH];
  logic                         acc_ovf_r [NCH];
  logic [acrms_pkg::UV_W-1:0]   zoff_r    [NCH];

  // Closed window being evaluated.
  logic [acrms_pkg::SUM_W-1:0]  win_sum_r;
  logic [acrms_pkg::SQ_W-1:0]   win_sq_r;
  logic [acrms_pkg::CNT_W-1:0]  win_n_r;
  logic                         win_ovf_r;
  logic                         win_cal_r;
  logic [acrms_pkg::CH_W-1:0]   win_chan_r;
  logic [acrms_pkg::GAIN_W-1:0] win_gain_r;
  logic [acrms_pkg::UV_W-1:0]   win_off_r;

  // Intermediate results.
  logic [acrms_pkg::ADC_BITS-1:0] a_r;
  logic [acrms_pkg::CNT_W-1:0]    b_r;
  logic [acrms_pkg::SQ_W-1:0]     w_r;
  logic [acrms_pkg::RAD_W-1:0]    v1_r;
  logic [acrms_pkg::MUL_W-1:0]    f_r;
  logic [acrms_pkg::ROOT_W-1:0]   rms_fx_r;
  logic [acrms_pkg::UV_W-1:0]     rms_uv_r;
  logic [acrms_pkg::UV_W-1:0]     mean_uv_r;
  logic [acrms_pkg::UA_W-1:0]     raw_ua_r;
  logic [acrms_pkg::UA_W-1:0]     off_ua_r;

  // Serial units.
  logic [acrms_pkg::MUL_W-1:0]    mu_a_r;
  logic [2*acrms_pkg::MUL_W-1:0]  mu_p_r;
  logic [acrms_pkg::DIV_W-1:0]    dv_dq_r;
  logic [acrms_pkg::DVS_W-1:0]    dv_rem_r;
  logic [acrms_pkg::DVS_W-1:0]    dv_dvs_r;
  logic [acrms_pkg::RAD_W-1:0]    sq_rad_r;
  logic [acrms_pkg::SQREM_W-1:0]  sq_rem_r;
  logic [acrms_pkg::ROOT_W-1:0]   sq_root_r;

  // Output register.
  logic                         out_valid_r;
  logic [acrms_pkg::CH_W-1:0]   out_chan_r;
  logic [acrms_pkg::UA_W-1:0]   out_corr_r;
  logic [acrms_pkg::UA_W-1:0]   out_raw_r;
  logic [acrms_pkg::UA_W-1:0]   out_off_r;
  logic [acrms_pkg::UV_W-1:0]   out_rms_r;
  logic [acrms_pkg::UV_W-1:0]   out_mean_r;
  logic [acrms_pkg::CNT_W-1:0]  out_n_r;
  logic                         out_clip_r;
  logic                         out_upd_r;

  // ---------------------------------------------------------------- accumulation
  logic                         in_fire, ch_ok, win_close, acc_full;
  logic [acrms_pkg::CH_W-1:0]   ch_sel;
  logic [2*acrms_pkg::ADC_BITS-1:0] code_sq;
  logic [acrms_pkg::SUM_W-1:0]  sum_nxt;
  logic [acrms_pkg::SQ_W-1:0]   sq_nxt;
  logic [acrms_pkg::CNT_W-1:0]  cnt_nxt;
  logic                         ovf_nxt;

  assign in_fire   = in_valid & in_ready;
  assign ch_ok     = in_chan < acrms_pkg::CH_W'(NCH);
  assign ch_sel    = ch_ok ? in_chan : '0;
  assign win_close = in_fire & ch_ok & in_window_end;
  assign acc_full  = acc_cnt_r[ch_sel] == acrms_pkg::CNT_W'(acrms_pkg::MAX_WINDOW);
  assign code_sq   = (2*acrms_pkg::ADC_BITS)'(in_raw_sample)
                   * (2*acrms_pkg::ADC_BITS)'(in_raw_sample);

  // A sample that arrives on a full window is dropped and only marks the window.
  assign sum_nxt = acc_full ? acc_sum_r[ch_sel]
                            : acc_sum_r[ch_sel] + acrms_pkg::SUM_W'(in_raw_sample);
  assign sq_nxt  = acc_full ? acc_sq_r[ch_sel]
                            : acc_sq_r[ch_sel] + acrms_pkg::SQ_W'(code_sq);
  assign cnt_nxt = acc_full ? acc_cnt_r[ch_sel]
                            : acc_cnt_r[ch_sel] + acrms_pkg::CNT_W'(1);
  assign ovf_nxt = acc_ovf_r[ch_sel] | acc_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r[0] <= acrms_pkg::GAIN_ONE_RESET;
      gain_r[1] <= acrms_pkg::GAIN_TWO_RESET;
      gain_r[2] <= acrms_pkg::GAIN_THREE_RESET;
      zoff_r[0] <= acrms_pkg::OFFSET_ONE_RESET;
      zoff_r[1] <= acrms_pkg::OFFSET_TWO_RESET;
      zoff_r[2] <= acrms_pkg::OFFSET_THREE_RESET;
      for (int i = 0; i < NCH; i++) begin
        acc_sum_r[i] <= '0;
        acc_sq_r[i]  <= '0;
        acc_cnt_r[i] <= '0;
        acc_ovf_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          acrms_pkg::REG_GAIN_ONE:   gain_r[0] <= cfg_wdata;
          acrms_pkg::REG_GAIN_TWO:   gain_r[1] <= cfg_wdata;
          acrms_pkg::REG_GAIN_THREE: gain_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire && ch_ok) begin
        if (in_window_end) begin
          acc_sum_r[ch_sel] <= '0;
          acc_sq_r[ch_sel]  <= '0;
          acc_cnt_r[ch_sel] <= '0;
          acc_ovf_r[ch_sel] <= 1'b0;
        end else begin
          acc_sum_r[ch_sel] <= sum_nxt;
          acc_sq_r[ch_sel]  <= sq_nxt;
          acc_cnt_r[ch_sel] <= cnt_nxt;
          acc_ovf_r[ch_sel] <= ovf_nxt;
        end
      end
      // The new offset only applies from the next window of this channel.
      if (out_load && win_cal_r) begin
        zoff_r[win_chan_r] <= rms_uv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_close) begin
      win_sum_r  <= sum_nxt;
      win_sq_r   <= sq_nxt;
      win_n_r    <= cnt_nxt;
      win_ovf_r  <= ovf_nxt;
      win_cal_r  <= in_calibrate;
      win_chan_r <= ch_sel;
      win_gain_r <= gain_r[ch_sel];
      win_off_r  <= zoff_r[ch_sel];
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      acrms_pkg::ST_IDLE:  if (win_close) state_nxt = acrms_pkg::ST_LOAD;
      acrms_pkg::ST_LOAD:  state_nxt = acrms_pkg::ST_RUN;
      acrms_pkg::ST_RUN:   if (step_r == '0) state_nxt = acrms_pkg::ST_STORE;
      acrms_pkg::ST_STORE: begin
        if (op_r == acrms_pkg::OP_OFF_DIV) state_nxt = acrms_pkg::ST_DONE;
        else state_nxt = acrms_pkg::ST_LOAD;
      end
      acrms_pkg::ST_DONE:  if (out_free) state_nxt = acrms_pkg::ST_IDLE;
      default:             state_nxt = acrms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    unit_load = 1'b0;
    unit_step = 1'b0;
    res_store = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      acrms_pkg::ST_IDLE:  in_ready  = 1'b1;
      acrms_pkg::ST_LOAD:  unit_load = 1'b1;
      acrms_pkg::ST_RUN:   unit_step = 1'b1;
      acrms_pkg::ST_STORE: res_store = 1'b1;
      acrms_pkg::ST_DONE:  out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acrms_pkg::ST_IDLE;
      op_r    <= acrms_pkg::OP_SPLIT;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (win_close) begin
        op_r <= acrms_pkg::OP_SPLIT;
      end else if (res_store) begin
        op_r <= acrms_pkg::op_next(op_r);
      end
      if (unit_load) begin
        step_r <= acrms_pkg::op_steps(op_r) - acrms_pkg::STEP_W'(1);
      end else if (unit_step) begin
        step_r <= step_r - acrms_pkg::STEP_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- operand selection
  logic [acrms_pkg::MUL_W-1:0] mul_a_sel, mul_b_sel;
  logic [acrms_pkg::DIV_W-1:0] div_num_sel;
  logic [acrms_pkg::DVS_W-1:0] div_den_sel;
  logic [acrms_pkg::DVS_W:0]   n_scaled;

  // ADC_MAX * n, the denominator of the mean.
  assign n_scaled = (acrms_pkg::DVS_W+1)'({win_n_r, {acrms_pkg::ADC_BITS{1'b0}}})
                  - (acrms_pkg::DVS_W+1)'(win_n_r);

  always_comb begin
    mul_a_sel   = '0;
    mul_b_sel   = '0;
    div_num_sel = acrms_pkg::DIV_W'(mu_p_r);
    div_den_sel = acrms_pkg::DVS_W'(win_n_r);
    case (op_r)
      acrms_pkg::OP_SPLIT:    div_num_sel = acrms_pkg::DIV_W'(win_sum_r);
      // a*a*n + 2*a*b is folded into a * (S + b).
      acrms_pkg::OP_SUB: begin
        mul_a_sel = acrms_pkg::MUL_W'(win_sum_r) + acrms_pkg::MUL_W'(b_r);
        mul_b_sel = acrms_pkg::MUL_W'(a_r);
      end
      acrms_pkg::OP_VAR:      div_num_sel = acrms_pkg::DIV_W'({w_r, 32'd0});
      acrms_pkg::OP_FRAC:     div_num_sel = acrms_pkg::DIV_W'({b_r, 32'd0});
      acrms_pkg::OP_FSQ: begin
        mul_a_sel = f_r;
        mul_b_sel = f_r;
      end
      acrms_pkg::OP_RMS_MUL: begin
        mul_a_sel = acrms_pkg::MUL_W'(rms_fx_r);
        mul_b_sel = acrms_pkg::MUL_W'(acrms_pkg::FULL_SCALE_UV);
      end
      acrms_pkg::OP_RMS_DIV:  div_den_sel = acrms_pkg::DVS_W'(acrms_pkg::RMS_DEN);
      acrms_pkg::OP_MEAN_MUL: begin
        mul_a_sel = acrms_pkg::MUL_W'(win_sum_r);
        mul_b_sel = acrms_pkg::MUL_W'(acrms_pkg::FULL_SCALE_UV);
      end
      acrms_pkg::OP_MEAN_DIV: div_den_sel = n_scaled[acrms_pkg::DVS_W-1:0];
      acrms_pkg::OP_RAW_MUL: begin
        mul_a_sel = acrms_pkg::MUL_W'(rms_uv_r);
        mul_b_sel = acrms_pkg::MUL_W'(win_gain_r);
      end
      acrms_pkg::OP_RAW_DIV:  div_den_sel = acrms_pkg::DVS_W'(acrms_pkg::UA_DIV);
      acrms_pkg::OP_OFF_MUL: begin
        mul_a_sel = acrms_pkg::MUL_W'(win_off_r);
        mul_b_sel = acrms_pkg::MUL_W'(win_gain_r);
      end
      acrms_pkg::OP_OFF_DIV:  div_den_sel = acrms_pkg::DVS_W'(acrms_pkg::UA_DIV);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- serial units
  acrms_pkg::unit_t cur_unit;
  logic [acrms_pkg::MUL_W:0]     mu_sum;
  logic [acrms_pkg::DVS_W:0]     dv_sh, dv_diff;
  logic                          dv_ge;
  logic [acrms_pkg::SQREM_W+1:0] sq_sh, sq_trial, sq_diff;
  logic                          sq_ge;

  assign cur_unit = acrms_pkg::op_unit(op_r);

  // Shift-add multiplier: one multiplier bit a cycle, product builds from the top.
  assign mu_sum = {1'b0, mu_p_r[2*acrms_pkg::MUL_W-1:acrms_pkg::MUL_W]}
                + (mu_p_r[0] ? {1'b0, mu_a_r} : '0);

  // Restoring divider: one quotient bit a cycle, quotient shifts into the dividend.
  assign dv_sh   = {dv_rem_r, dv_dq_r[acrms_pkg::DIV_W-1]};
  assign dv_ge   = dv_sh >= {1'b0, dv_dvs_r};
  assign dv_diff = dv_sh - {1'b0, dv_dvs_r};

  // Square root: two radicand bits and one root bit a cycle.
  assign sq_sh    = {sq_rem_r, sq_rad_r[acrms_pkg::RAD_W-1 -: 2]};
  assign sq_trial = (acrms_pkg::SQREM_W+2)'({sq_root_r, 2'b01});
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_diff  = sq_sh - sq_trial;

  always_ff @(posedge clk) begin
    if (unit_load) begin
      mu_a_r    <= mul_a_sel;
      mu_p_r    <= (2*acrms_pkg::MUL_W)'(mul_b_sel);
      dv_dq_r   <= div_num_sel;
      dv_dvs_r  <= div_den_sel;
      dv_rem_r  <= '0;
      sq_rad_r  <= v1_r;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (unit_step) begin
      case (cur_unit)
        acrms_pkg::UNIT_MUL: begin
          mu_p_r <= {mu_sum, mu_p_r[acrms_pkg::MUL_W-1:1]};
        end
        acrms_pkg::UNIT_SQRT: begin
          sq_rem_r  <= sq_ge ? sq_diff[acrms_pkg::SQREM_W-1:0]
                             : sq_sh[acrms_pkg::SQREM_W-1:0];
          sq_root_r <= {sq_root_r[acrms_pkg::ROOT_W-2:0], sq_ge};
          sq_rad_r  <= {sq_rad_r[acrms_pkg::RAD_W-3:0], 2'b00};
        end
        default: begin
          dv_rem_r <= dv_ge ? dv_diff[acrms_pkg::DVS_W-1:0] : dv_sh[acrms_pkg::DVS_W-1:0];
          dv_dq_r  <= {dv_dq_r[acrms_pkg::DIV_W-2:0], dv_ge};
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- result capture
  logic [acrms_pkg::SQ_W:0]   sub_val;
  logic [acrms_pkg::MUL_W-1:0] fsq_hi;

  assign sub_val = mu_p_r[acrms_pkg::SQ_W:0];
  assign fsq_hi  = mu_p_r[2*acrms_pkg::MUL_W-1:acrms_pkg::MUL_W];

  always_ff @(posedge clk) begin
    if (res_store) begin
      case (op_r)
        acrms_pkg::OP_SPLIT: begin
          a_r <= dv_dq_r[acrms_pkg::ADC_BITS-1:0];
          b_r <= dv_rem_r[acrms_pkg::CNT_W-1:0];
        end
        // A negative variance numerator leaves the RMS at zero.
        acrms_pkg::OP_SUB: begin
          if ({1'b0, win_sq_r} >= sub_val) begin
            w_r <= win_sq_r - sub_val[acrms_pkg::SQ_W-1:0];
          end else begin
            w_r <= '0;
          end
        end
        acrms_pkg::OP_VAR:  v1_r <= dv_dq_r[acrms_pkg::RAD_W-1:0];
        acrms_pkg::OP_FRAC: f_r  <= dv_dq_r[acrms_pkg::MUL_W-1:0];
        acrms_pkg::OP_FSQ: begin
          if (v1_r > acrms_pkg::RAD_W'(fsq_hi)) begin
            v1_r <= v1_r - acrms_pkg::RAD_W'(fsq_hi);
          end else begin
            v1_r <= '0;
          end
        end
        acrms_pkg::OP_ROOT:     rms_fx_r  <= sq_root_r;
        acrms_pkg::OP_RMS_DIV:  rms_uv_r  <= dv_dq_r[acrms_pkg::UV_W-1:0];
        acrms_pkg::OP_MEAN_DIV: mean_uv_r <= dv_dq_r[acrms_pkg::UV_W-1:0];
        acrms_pkg::OP_RAW_DIV:  raw_ua_r  <= dv_dq_r[acrms_pkg::UA_W-1:0];
        acrms_pkg::OP_OFF_DIV:  off_ua_r  <= dv_dq_r[acrms_pkg::UA_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r <= win_chan_r;
      out_corr_r <= (raw_ua_r > off_ua_r) ? raw_ua_r - off_ua_r : '0;
      out_raw_r  <= raw_ua_r;
      out_off_r  <= off_ua_r;
      out_rms_r  <= rms_uv_r;
      out_mean_r <= mean_uv_r;
      out_n_r    <= win_n_r;
      out_clip_r <= win_ovf_r;
      out_upd_r  <= win_cal_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_result_chan          = out_chan_r;
  assign out_corrected_current_ua = out_corr_r;
  assign out_raw_current_ua       = out_raw_r;
  assign out_offset_current_ua    = out_off_r;
  assign out_rms_voltage_uv       = out_rms_r;
  assign out_mean_voltage_uv      = out_mean_r;
  assign out_samples_used         = out_n_r;
  assign out_window_clipped       = out_clip_r;
  assign out_offset_updated       = out_upd_r;

  // ---------------------------------------------------------------- assertions
  a_close_starts: assert property (@(posedge clk) disable iff (!rst_n)
    win_close |=> (state_r == acrms_pkg::ST_LOAD) && (op_r == acrms_pkg::OP_SPLIT))
    else $error("closing sample did not start the window evaluation");

  a_mean_code_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (res_store && op_r == acrms_pkg::OP_SPLIT)
      |-> (dv_dq_r[acrms_pkg::DIV_W-1:acrms_pkg::ADC_BITS] == '0))
    else $error("mean code exceeds the ADC range");

  a_var_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (res_store && op_r == acrms_pkg::OP_VAR)
      |-> (dv_dq_r[acrms_pkg::DIV_W-1:acrms_pkg::RAD_W] == '0))
    else $error("variance quotient wider than the root radicand");

  a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_corr_r <= out_raw_r)
      && (!out_clip_r || out_n_r == acrms_pkg::CNT_W'(acrms_pkg::MAX_WINDOW)))
    else $error("inconsistent result fields");

endmodule
